[hw/rtl/cmmd_pkg.sv]
// ----------------------------------------------------------------------------
// cmmd_pkg
// Shared constants and types of the multichannel CAN message deframer.
// ----------------------------------------------------------------------------
package cmmd_pkg;

  localparam int unsigned CHANNELS   = 3;
  localparam int unsigned BODY_BYTES = 128;
  localparam int unsigned CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned BODY_W     = $clog2(BODY_BYTES + 1);
  localparam int unsigned HDR_LEN    = 4;

  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  localparam logic [10:0] ID_CH0 = 11'h090;
  localparam logic [10:0] ID_CH1 = 11'h108;
  localparam logic [10:0] ID_CH2 = 11'h7F8;

  localparam logic [7:0] HDR_A = 8'h55;
  localparam logic [7:0] HDR_B = 8'hAA;
  localparam logic [7:0] FTR_A = 8'h66;
  localparam logic [7:0] FTR_B = 8'hCC;

  localparam logic [6:0] MAX_FRAME_RESET = 7'd8;

  // framer phases
  localparam logic [3:0] PH_SYNC1   = 4'd1;
  localparam logic [3:0] PH_SYNC3   = 4'd3;
  localparam logic [3:0] PH_ID_LO   = 4'd4;
  localparam logic [3:0] PH_ID_HI   = 4'd5;
  localparam logic [3:0] PH_LEN_LO  = 4'd6;
  localparam logic [3:0] PH_LEN_HI  = 4'd7;
  localparam logic [3:0] PH_PAYLOAD = 4'd8;
  localparam logic [3:0] PH_FTR0    = 4'd9;
  localparam logic [3:0] PH_FTR1    = 4'd10;
  localparam logic [3:0] PH_FTR3    = 4'd12;
  localparam logic [3:0] PH_DONE    = 4'd13;

  // footer watcher phases
  localparam logic [2:0] WATCH_A1   = 3'd1;
  localparam logic [2:0] WATCH_B1   = 3'd3;
  localparam logic [2:0] WATCH_DONE = 3'd4;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_DROP    = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [3:0]        phase;
    logic [2:0]        watch;
    logic [BODY_W-1:0] body;
    logic [15:0]       ident;
    logic [15:0]       length;
  } chan_state_t;

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  channel;
    logic [7:0]  value;
    logic [6:0]  offset;
    logic [15:0] ident;
    logic [15:0] length;
    logic [15:0] err_total;
    logic        is_last;
  } result_t;

endpackage

[hw/rtl/cmmd_in_if.sv]
// ----------------------------------------------------------------------------
// cmmd_in_if
// Byte channel into the deframer: one CAN data byte and its frame attributes.
// ----------------------------------------------------------------------------
interface cmmd_in_if;
  logic        valid;
  logic        ready;
  logic [10:0] frame_ident;
  logic        error_frame;
  logic        extended_format;
  logic        remote_request;
  logic [5:0]  byte_position;
  logic [7:0]  data_byte;

  modport source (
    output valid, frame_ident, error_frame, extended_format, remote_request,
           byte_position, data_byte,
    input  ready
  );
  modport sink (
    input  valid, frame_ident, error_frame, extended_format, remote_request,
           byte_position, data_byte,
    output ready
  );
endinterface

[hw/rtl/cmmd_out_if.sv]
// ----------------------------------------------------------------------------
// cmmd_out_if
// Result channel out of the deframer: payload, done, drop and error beats.
// ----------------------------------------------------------------------------
interface cmmd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  channel;
  logic [7:0]  payload_value;
  logic [6:0]  payload_offset;
  logic [15:0] message_ident;
  logic [15:0] message_length;
  logic [15:0] error_total;
  logic        is_last;

  modport source (
    output valid, kind, channel, payload_value, payload_offset, message_ident,
           message_length, error_total, is_last,
    input  ready
  );
  modport sink (
    input  valid, kind, channel, payload_value, payload_offset, message_ident,
           message_length, error_total, is_last,
    output ready
  );
endinterface

[hw/rtl/can_multichannel_message_deframer.sv]
// Results: an accepted byte is registered in stage 1, then its result beats
// enter the result queue that drives the output; a second follows the first.
// Throughput: one byte per cycle while the four-entry result queue has room;
// the output drains one beat per cycle, so two-result bytes are held back.
// Reset: channel state reads as zero until a channel entry is first written
// (per-entry valid bits); error count zero; frame cap back to 8.
// ----------------------------------------------------------------------------
// can_multichannel_message_deframer
// Per-channel message framer over a channel state memory with write-back
// forwarding, footer watcher, saturating error count and a result queue.
// ----------------------------------------------------------------------------
module can_multichannel_message_deframer import cmmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  cmmd_in_if.sink     cmd_i,
  cmmd_out_if.source  res_o
);

  logic [6:0] max_q;

  // stage 0 decode
  logic [1:0]          ch_num;
  logic                id_hit;
  logic                in_use;
  logic                in_acc;
  logic [CH_IDX_W-1:0] rd_idx;

  // stage 1
  logic                s1_valid_q, s1_err_q, s1_use_q;
  logic [CH_IDX_W-1:0] s1_ch_q;
  logic [7:0]          s1_byte_q;
  logic                fwd_q, rdv_q;
  chan_state_t         rd_q, wb_q;
  logic                s1_adv;

  chan_state_t         mem_q [CHANNELS];
  logic [CHANNELS-1:0] valid_q;
  logic                mem_we;
  logic [CH_IDX_W-1:0] wr_idx;

  chan_state_t st, st_d;
  logic        active, restart_f, drop_f, emit_p, done_f, fin, drop_r;
  logic [2:0]  fw_base;
  logic [BODY_W-1:0] body_n;
  logic [16:0] len_lim;

  logic [15:0] err_q, err_d;
  result_t     r0, r1, pay_r, done_r, drop_r_t;
  logic [1:0]  n_res;

  // result queue
  result_t             oq_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wp_q, rp_q;
  logic [OQ_CNT_W-1:0] cnt_q, cnt_pop;
  logic                pop;

  always_comb begin
    ch_num = 2'd0;
    id_hit = 1'b1;
    case (cmd_i.frame_ident)
      ID_CH0:  ch_num = 2'd0;
      ID_CH1:  ch_num = 2'd1;
      ID_CH2:  ch_num = 2'd2;
      default: id_hit = 1'b0;
    endcase
  end

  assign in_use = !cmd_i.error_frame && !cmd_i.extended_format && !cmd_i.remote_request &&
                  id_hit && (int'(ch_num) < CHANNELS) && ({1'b0, cmd_i.byte_position} < max_q);
  assign rd_idx = ch_num[CH_IDX_W-1:0];
  assign in_acc = cmd_i.valid && cmd_i.ready;

  assign pop     = res_o.valid && res_o.ready;
  assign cnt_pop = cnt_q - OQ_CNT_W'(pop);
  assign s1_adv  = s1_valid_q && ((cnt_pop + OQ_CNT_W'(n_res)) <= OQ_CNT_W'(OQ_DEPTH));
  assign cmd_i.ready = !s1_valid_q || s1_adv;

  assign mem_we = s1_adv && s1_use_q;
  assign wr_idx = s1_ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_FRAME_RESET;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      valid_q    <= '0;
      err_q      <= '0;
      fwd_q      <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= mem_we && (wr_idx == rd_idx);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (mem_we) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (s1_adv) begin
        err_q <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_idx] <= st_d;
      wb_q          <= st_d;
    end
    if (in_acc) begin
      s1_err_q  <= cmd_i.error_frame;
      s1_use_q  <= in_use;
      s1_ch_q   <= rd_idx;
      s1_byte_q <= cmd_i.data_byte;
      if (in_use) begin
        rd_q  <= mem_q[rd_idx];
        rdv_q <= valid_q[rd_idx];
      end
    end
  end

  assign st      = fwd_q ? wb_q : (rdv_q ? rd_q : '0);
  assign active  = (st.phase >= PH_ID_LO) && (st.phase <= PH_FTR3);
  assign len_lim = {1'b0, st.length} + 17'(HDR_LEN);
  assign body_n  = (st.body < BODY_W'(BODY_BYTES)) ? st.body + 1'b1 : st.body;

  always_comb begin
    st_d      = st;
    restart_f = 1'b0;
    drop_f    = 1'b0;
    emit_p    = 1'b0;
    if (st.phase <= PH_SYNC1) begin
      if (s1_byte_q == HDR_A) st_d.phase = st.phase + 1'b1;
      else restart_f = 1'b1;
    end else if (st.phase <= PH_SYNC3) begin
      if (s1_byte_q == HDR_B) begin
        st_d.phase = st.phase + 1'b1;
        st_d.body  = '0;
      end else begin
        restart_f = 1'b1;
      end
    end else if (st.phase <= PH_LEN_HI) begin
      case (st.phase)
        PH_ID_LO:  st_d.ident[7:0]   = s1_byte_q;
        PH_ID_HI:  st_d.ident[15:8]  = s1_byte_q;
        PH_LEN_LO: st_d.length[7:0]  = s1_byte_q;
        default:   st_d.length[15:8] = s1_byte_q;
      endcase
      st_d.body  = BODY_W'(st.phase - 4'd3);
      st_d.phase = st.phase + 1'b1;
    end else if (st.phase == PH_PAYLOAD) begin
      if (st.length > 16'(BODY_BYTES - HDR_LEN)) begin
        restart_f = 1'b1;
        drop_f    = 1'b1;
      end else begin
        emit_p    = 1'b1;
        st_d.body = body_n;
        if (17'(body_n) >= len_lim) st_d.phase = PH_FTR0;
      end
    end else if (st.phase <= PH_FTR1) begin
      if (s1_byte_q == FTR_A) st_d.phase = st.phase + 1'b1;
      else begin
        restart_f = 1'b1;
        drop_f    = 1'b1;
      end
    end else if (st.phase <= PH_FTR3) begin
      if (s1_byte_q == FTR_B) st_d.phase = st.phase + 1'b1;
      else begin
        restart_f = 1'b1;
        drop_f    = 1'b1;
      end
    end else begin
      restart_f = 1'b1;
    end

    if (restart_f) begin
      st_d.phase  = '0;
      st_d.ident  = '0;
      st_d.length = '0;
    end
    fw_base = restart_f ? 3'd0 : st.watch;
    if (fw_base <= WATCH_A1) begin
      st_d.watch = (s1_byte_q == FTR_A) ? fw_base + 1'b1 : 3'd0;
    end else if (fw_base <= WATCH_B1) begin
      st_d.watch = (s1_byte_q == FTR_B) ? fw_base + 1'b1 : 3'd0;
    end else begin
      st_d.watch = 3'd0;
    end

    fin    = (st_d.phase == PH_DONE) || (st_d.watch == WATCH_DONE);
    done_f = (st_d.phase == PH_DONE) && (st_d.watch == WATCH_DONE);
    if (fin && !done_f && active) drop_f = 1'b1;
    if (fin) begin
      st_d.phase  = '0;
      st_d.watch  = '0;
      st_d.ident  = '0;
      st_d.length = '0;
    end
    drop_r = drop_f && active;
  end

  assign err_d = (s1_err_q && (err_q != 16'hFFFF)) ? err_q + 1'b1 : err_q;

  always_comb begin
    pay_r           = '0;
    pay_r.kind      = KIND_PAYLOAD;
    pay_r.channel   = 2'(s1_ch_q);
    pay_r.value     = s1_byte_q;
    pay_r.offset    = st.body[6:0];
    pay_r.ident     = st.ident;
    pay_r.length    = st.length;
    pay_r.err_total = err_d;

    done_r          = pay_r;
    done_r.kind     = KIND_DONE;
    done_r.value    = '0;
    done_r.offset   = '0;

    drop_r_t        = done_r;
    drop_r_t.kind   = KIND_DROP;

    r0    = '0;
    r1    = drop_r_t;
    n_res = 2'd0;
    if (s1_err_q) begin
      r0.kind      = KIND_ERROR;
      r0.err_total = err_d;
      n_res        = 2'd1;
    end else if (s1_use_q) begin
      if (emit_p) r0 = pay_r;
      else if (done_f) r0 = done_r;
      else r0 = drop_r_t;
      n_res = 2'(emit_p) + 2'(done_f) + 2'(drop_r);
    end
    r0.is_last = (n_res == 2'd1);
    r1.is_last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (pop) rp_q <= rp_q + 1'b1;
      if (s1_adv) begin
        wp_q  <= wp_q + OQ_PTR_W'(n_res);
        cnt_q <= cnt_pop + OQ_CNT_W'(n_res);
      end else begin
        cnt_q <= cnt_pop;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && (n_res != 2'd0)) oq_q[wp_q] <= r0;
    if (s1_adv && (n_res == 2'd2)) oq_q[wp_q + 1'b1] <= r1;
  end

  assign res_o.valid          = (cnt_q != '0);
  assign res_o.kind           = oq_q[rp_q].kind;
  assign res_o.channel        = oq_q[rp_q].channel;
  assign res_o.payload_value  = oq_q[rp_q].value;
  assign res_o.payload_offset = oq_q[rp_q].offset;
  assign res_o.message_ident  = oq_q[rp_q].ident;
  assign res_o.message_length = oq_q[rp_q].length;
  assign res_o.error_total    = oq_q[rp_q].err_total;
  assign res_o.is_last        = oq_q[rp_q].is_last;

endmodule

[hw/rtl/cmmd_checker.sv]
// ----------------------------------------------------------------------------
// cmmd_checker
// Port-level checks on the deframer result channel, bound to the top level.
// ----------------------------------------------------------------------------
module cmmd_checker import cmmd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic [1:0]  kind_i,
  input logic [1:0]  channel_i,
  input logic [7:0]  value_i,
  input logic [6:0]  offset_i,
  input logic [15:0] ident_i,
  input logic [15:0] total_i,
  input logic        last_i
);

  a_err_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (kind_i == KIND_ERROR) |->
      last_i && (channel_i == 2'd0) && (ident_i == 16'd0) && (total_i != 16'd0))
    else $error("error beat malformed");

  a_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (kind_i != KIND_PAYLOAD) |-> (value_i == 8'd0) && (offset_i == 7'd0))
    else $error("non-payload beat carries payload");

  a_total_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_i |=> !valid_i || (total_i >= $past(total_i)))
    else $error("error total went down");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(total_i) && $stable(kind_i))
    else $error("stalled beat changed");

endmodule

bind can_multichannel_message_deframer cmmd_checker u_cmmd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .valid_i   (res_o.valid),
  .ready_i   (res_o.ready),
  .kind_i    (res_o.kind),
  .channel_i (res_o.channel),
  .value_i   (res_o.payload_value),
  .offset_i  (res_o.payload_offset),
  .ident_i   (res_o.message_ident),
  .total_i   (res_o.error_total),
  .last_i    (res_o.is_last)
);

[tb/can_multichannel_message_deframer_test.sv]
// ----------------------------------------------------------------------------
// can_multichannel_message_deframer_test
// Drives CAN data bytes into the deframer and checks every result beat
// against a cycle-free model of the three channel framers, footer watchers and
// error counter. Directed messages come first, then interleaved random
// messages with flaws and noise under several frame caps, then a burst of
// error frames.
// ----------------------------------------------------------------------------
module can_multichannel_message_deframer_test;
  import cmmd_pkg::*;

  typedef struct packed {
    logic [10:0] ident;
    logic        error_frame;
    logic        extended_format;
    logic        remote_request;
    logic [5:0]  byte_position;
    logic [7:0]  data_byte;
  } can_byte_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_SYNC,
    FLAW_FOOTER,
    FLAW_EARLY_FOOTER,
    FLAW_CUT,
    FLAW_BARE_FOOTER
  } flaw_e;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we;
  logic [6:0] cfg_wdata;

  cmmd_in_if  can_bytes ();
  cmmd_out_if deframed ();

  can_multichannel_message_deframer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .cmd_i       (can_bytes),
    .res_o       (deframed)
  );

  always #6 clk_i = ~clk_i;

  // channel model state
  logic [3:0]  framer_ph [CHANNELS];
  logic [2:0]  watch_ph  [CHANNELS];
  int unsigned body_cnt  [CHANNELS];
  logic [15:0] msg_id    [CHANNELS];
  logic [15:0] msg_len   [CHANNELS];
  logic [15:0] err_count;
  logic [6:0]  frame_cap;

  result_t    pending_beats [$];
  logic [7:0] stream_q [CHANNELS][$];
  result_t    next_beat;
  int         mismatch_count = 0;
  int         taken_items = 0;
  int         stall_left = 0;
  bit         idle_en = 1'b1;

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  function automatic int channel_of(logic [10:0] ident);
    case (ident)
      ID_CH0:  return 0;
      ID_CH1:  return 1;
      ID_CH2:  return 2;
      default: return -1;
    endcase
  endfunction

  function automatic logic [10:0] ident_of(int ch);
    case (ch)
      0:       return ID_CH0;
      1:       return ID_CH1;
      default: return ID_CH2;
    endcase
  endfunction

  function automatic void restart_channel(int ch);
    framer_ph[ch] = '0;
    watch_ph[ch]  = '0;
    msg_id[ch]    = '0;
    msg_len[ch]   = '0;
  endfunction

  function automatic result_t make_beat(kind_e k, int ch, logic [7:0] v, logic [6:0] off,
                                        logic [15:0] id, logic [15:0] len);
    result_t r;
    r.kind      = k;
    r.channel   = ch[1:0];
    r.value     = v;
    r.offset    = off;
    r.ident     = id;
    r.length    = len;
    r.err_total = err_count;
    r.is_last   = 1'b0;
    return r;
  endfunction

  // Advance the model by one byte and queue the beats it yields.
  // Returns 0 for a byte the block ignores.
  function automatic bit deframe_byte(can_byte_t cb);
    result_t     beats [$];
    int          ch;
    logic [3:0]  ph;
    logic [2:0]  fw;
    logic [7:0]  d;
    bit          active;
    bit          dropped;
    logic [15:0] id0;
    logic [15:0] len0;
    dropped = 1'b0;
    d = cb.data_byte;
    if (cb.error_frame) begin
      if (err_count != 16'hFFFF) err_count++;
      beats.push_back(make_beat(KIND_ERROR, 0, '0, '0, '0, '0));
    end else begin
      ch = channel_of(cb.ident);
      if (cb.extended_format || cb.remote_request || ch < 0 || ch >= CHANNELS ||
          {1'b0, cb.byte_position} >= frame_cap) begin
        return 1'b0;
      end
      ph = framer_ph[ch];
      active = ph >= PH_ID_LO && ph <= PH_FTR3;
      id0 = msg_id[ch];
      len0 = msg_len[ch];
      if (ph <= PH_SYNC1) begin
        if (d == HDR_A) framer_ph[ch] = ph + 4'd1;
        else restart_channel(ch);
      end else if (ph <= PH_SYNC3) begin
        if (d == HDR_B) begin
          framer_ph[ch] = ph + 4'd1;
          body_cnt[ch] = 0;
        end else begin
          restart_channel(ch);
        end
      end else if (ph <= PH_LEN_HI) begin
        case (ph)
          PH_ID_LO:  msg_id[ch][7:0]   = d;
          PH_ID_HI:  msg_id[ch][15:8]  = d;
          PH_LEN_LO: msg_len[ch][7:0]  = d;
          default:   msg_len[ch][15:8] = d;
        endcase
        body_cnt[ch] = int'(ph - PH_SYNC3);
        framer_ph[ch] = ph + 4'd1;
      end else if (ph == PH_PAYLOAD) begin
        if (msg_len[ch] > BODY_BYTES - HDR_LEN) begin
          restart_channel(ch);
          dropped = 1'b1;
        end else begin
          beats.push_back(make_beat(KIND_PAYLOAD, ch, d, body_cnt[ch][6:0], id0, len0));
          if (body_cnt[ch] < BODY_BYTES) body_cnt[ch]++;
          if (body_cnt[ch] >= msg_len[ch] + HDR_LEN) framer_ph[ch] = PH_FTR0;
        end
      end else if (ph <= PH_FTR1) begin
        if (d == FTR_A) begin
          framer_ph[ch] = ph + 4'd1;
        end else begin
          restart_channel(ch);
          dropped = 1'b1;
        end
      end else if (ph <= PH_FTR3) begin
        if (d == FTR_B) begin
          framer_ph[ch] = ph + 4'd1;
        end else begin
          restart_channel(ch);
          dropped = 1'b1;
        end
      end else begin
        restart_channel(ch);
      end

      fw = watch_ph[ch];
      if (fw <= WATCH_A1) watch_ph[ch] = (d == FTR_A) ? fw + 3'd1 : 3'd0;
      else if (fw <= WATCH_B1) watch_ph[ch] = (d == FTR_B) ? fw + 3'd1 : 3'd0;
      else watch_ph[ch] = '0;

      if (framer_ph[ch] == PH_DONE || watch_ph[ch] == WATCH_DONE) begin
        if (framer_ph[ch] == PH_DONE && watch_ph[ch] == WATCH_DONE) begin
          beats.push_back(make_beat(KIND_DONE, ch, '0, '0, id0, len0));
        end else if (active) begin
          dropped = 1'b1;
        end
        restart_channel(ch);
      end
      if (dropped && active) beats.push_back(make_beat(KIND_DROP, ch, '0, '0, id0, len0));
    end
    if (beats.size() > 0) beats[beats.size() - 1].is_last = 1'b1;
    foreach (beats[i]) pending_beats.push_back(beats[i]);
    return 1'b1;
  endfunction

  function automatic can_byte_t make_byte(logic [10:0] ident, logic err, logic ext,
                                          logic rtr, logic [5:0] pos, logic [7:0] data);
    can_byte_t cb;
    cb.ident           = ident;
    cb.error_frame     = err;
    cb.extended_format = ext;
    cb.remote_request  = rtr;
    cb.byte_position   = pos;
    cb.data_byte       = data;
    return cb;
  endfunction

  function automatic can_byte_t channel_byte(int ch, logic [7:0] data);
    logic [5:0] pos;
    if (frame_cap == 0) pos = 6'($urandom);
    else pos = 6'($urandom_range(0, (frame_cap > 64 ? 64 : frame_cap) - 1));
    return make_byte(ident_of(ch), 1'b0, 1'b0, 1'b0, pos, data);
  endfunction

  function automatic can_byte_t random_noise();
    can_byte_t cb;
    cb = make_byte(11'($urandom), 1'b0, 1'b0, 1'b0, 6'($urandom), 8'($urandom));
    case ($urandom_range(0, 5))
      0: cb.error_frame = 1'b1;
      1: begin
        cb.extended_format = 1'b1;
        cb.remote_request = 1'($urandom);
        cb.ident = ident_of($urandom_range(0, 2));
      end
      2: begin
        cb.remote_request = 1'b1;
        cb.ident = ident_of($urandom_range(0, 2));
      end
      3: while (channel_of(cb.ident) >= 0) cb.ident = 11'($urandom);
      4: begin
        if (frame_cap < 64) begin
          cb.ident = ident_of($urandom_range(0, 2));
          cb.byte_position = 6'($urandom_range(frame_cap, 63));
        end else begin
          cb.error_frame = 1'b1;
        end
      end
      default: begin
        cb.extended_format = 1'($urandom);
        cb.remote_request = 1'($urandom);
      end
    endcase
    return cb;
  endfunction

  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 11))
      0:       return HDR_A;
      1:       return HDR_B;
      2:       return FTR_A;
      3:       return FTR_B;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_length();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick <= 11) return 16'($urandom_range(0, 12));
    if (pick <= 13) return 16'd0;
    if (pick <= 15) return 16'($urandom_range(13, BODY_BYTES - HDR_LEN));
    if (pick == 16) return 16'(BODY_BYTES - HDR_LEN);
    if (pick == 17) return 16'(BODY_BYTES - HDR_LEN + 1);
    if (pick == 18) return 16'hFFFF;
    return 16'($urandom_range(BODY_BYTES - HDR_LEN + 2, 65534));
  endfunction

  function automatic flaw_e random_flaw();
    case ($urandom_range(0, 9))
      5:       return FLAW_SYNC;
      6:       return FLAW_FOOTER;
      7:       return FLAW_EARLY_FOOTER;
      8:       return FLAW_CUT;
      9:       return FLAW_BARE_FOOTER;
      default: return FLAW_NONE;
    endcase
  endfunction

  // Queue the byte sequence of one message on a channel.
  function automatic void build_message(int ch, flaw_e flaw, logic [15:0] mid,
                                        logic [15:0] mlen);
    logic [7:0]  msg [$];
    int unsigned n;
    int unsigned at;
    if (flaw == FLAW_BARE_FOOTER) begin
      msg = '{FTR_A, FTR_A, FTR_B, FTR_B};
    end else begin
      msg = '{HDR_A, HDR_A, HDR_B, HDR_B, mid[7:0], mid[15:8], mlen[7:0], mlen[15:8]};
      if (mlen > BODY_BYTES - HDR_LEN) n = $urandom_range(1, 6);
      else n = (mlen == 0) ? 1 : mlen;
      repeat (n) msg.push_back(payload_byte());
      if (flaw == FLAW_EARLY_FOOTER) begin
        at = $urandom_range(8, msg.size());
        msg.insert(at, FTR_B);
        msg.insert(at, FTR_B);
        msg.insert(at, FTR_A);
        msg.insert(at, FTR_A);
      end
      msg.push_back(FTR_A);
      msg.push_back(FTR_A);
      msg.push_back(FTR_B);
      msg.push_back(FTR_B);
      if (flaw == FLAW_SYNC) begin
        at = $urandom_range(0, 3);
        msg[at] = msg[at] ^ 8'($urandom_range(1, 255));
      end else if (flaw == FLAW_FOOTER) begin
        at = msg.size() - 1 - $urandom_range(0, 3);
        msg[at] = msg[at] ^ 8'($urandom_range(1, 255));
      end else if (flaw == FLAW_CUT) begin
        at = $urandom_range(1, msg.size() - 1);
        while (msg.size() > at) void'(msg.pop_back());
      end
    end
    foreach (msg[i]) stream_q[ch].push_back(msg[i]);
  endfunction

  function automatic int busy_channel();
    int first;
    first = $urandom_range(0, CHANNELS - 1);
    for (int k = 0; k < CHANNELS; k++) begin
      if (stream_q[(first + k) % CHANNELS].size() != 0) return (first + k) % CHANNELS;
    end
    return -1;
  endfunction

  task automatic send_byte(can_byte_t cb);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      can_bytes.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    can_bytes.valid           <= 1'b1;
    can_bytes.frame_ident     <= cb.ident;
    can_bytes.error_frame     <= cb.error_frame;
    can_bytes.extended_format <= cb.extended_format;
    can_bytes.remote_request  <= cb.remote_request;
    can_bytes.byte_position   <= cb.byte_position;
    can_bytes.data_byte       <= cb.data_byte;
    do @(posedge clk_i); while (can_bytes.ready !== 1'b1);
    if (deframe_byte(cb)) taken_items++;
  endtask

  task automatic flush_streams();
    int ch;
    ch = busy_channel();
    while (ch >= 0) begin
      send_byte(channel_byte(ch, stream_q[ch].pop_front()));
      ch = busy_channel();
    end
  endtask

  task automatic hold_for_results();
    can_bytes.valid <= 1'b0;
    do @(posedge clk_i); while (pending_beats.size() != 0);
  endtask

  task automatic write_frame_cap(logic [6:0] cap);
    hold_for_results();
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    frame_cap = cap;
  endtask

  task automatic test_clean_message();
    build_message(0, FLAW_NONE, 16'hFFFF, 16'h0000);
    send_byte(make_byte(ID_CH0, 1'b0, 1'b0, 1'b0, 6'd8, HDR_B));
    flush_streams();
  endtask

  task automatic test_ignored_bytes();
    send_byte(make_byte(11'h7FF, 1'b1, 1'b1, 1'b1, 6'd63, 8'hFF));
    send_byte(make_byte(ID_CH1, 1'b0, 1'b1, 1'b0, 6'd0, HDR_A));
    send_byte(make_byte(ID_CH1, 1'b0, 1'b0, 1'b1, 6'd0, HDR_A));
    send_byte(make_byte(11'h000, 1'b0, 1'b0, 1'b0, 6'd0, 8'h00));
    send_byte(make_byte(11'h7FF, 1'b0, 1'b0, 1'b0, 6'd7, HDR_A));
  endtask

  task automatic test_dropped_messages();
    stream_q[1] = '{HDR_A, HDR_A, HDR_B, HDR_B, 8'h34, 8'h12, 8'hFF, 8'hFF, 8'h00};
    flush_streams();
    build_message(2, FLAW_BARE_FOOTER, '0, '0);
    flush_streams();
  endtask

  task automatic test_random_traffic(int budget);
    int start;
    int ch;
    bit paused;
    start = taken_items;
    paused = 1'b0;
    while (taken_items - start < budget) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (stream_q[c].size() == 0 && $urandom_range(0, 3) == 0) begin
          build_message(c, random_flaw(), 16'($urandom), random_length());
        end
      end
      ch = busy_channel();
      if (ch < 0 || $urandom_range(0, frame_cap == 0 ? 1 : 7) == 0) begin
        send_byte(random_noise());
      end else begin
        send_byte(channel_byte(ch, stream_q[ch].pop_front()));
      end
      if (!paused && taken_items - start >= budget / 2) begin
        hold_for_results();
        paused = 1'b1;
      end
    end
    flush_streams();
  endtask

  task automatic test_error_frames();
    repeat (40) send_byte(make_byte(11'($urandom), 1'b1, 1'($urandom), 1'($urandom),
                                    6'($urandom), 8'($urandom)));
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      deframed.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 15);
      deframed.ready <= 1'b0;
    end else begin
      deframed.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (deframed.valid === 1'b1 && deframed.ready === 1'b1) begin
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat of kind %0d", deframed.kind));
      end else begin
        next_beat = pending_beats.pop_front();
        check_field("kind", 16'(deframed.kind), 16'(next_beat.kind));
        check_field("channel", 16'(deframed.channel), 16'(next_beat.channel));
        check_field("payload_value", 16'(deframed.payload_value), 16'(next_beat.value));
        check_field("payload_offset", 16'(deframed.payload_offset), 16'(next_beat.offset));
        check_field("message_ident", deframed.message_ident, next_beat.ident);
        check_field("message_length", deframed.message_length, next_beat.length);
        check_field("error_total", deframed.error_total, next_beat.err_total);
        check_field("is_last", 16'(deframed.is_last), 16'(next_beat.is_last));
      end
    end
  end

  initial begin
    rst_ni                    <= 1'b0;
    cfg_we                    <= 1'b0;
    cfg_wdata                 <= '0;
    can_bytes.valid           <= 1'b0;
    can_bytes.frame_ident     <= '0;
    can_bytes.error_frame     <= 1'b0;
    can_bytes.extended_format <= 1'b0;
    can_bytes.remote_request  <= 1'b0;
    can_bytes.byte_position   <= '0;
    can_bytes.data_byte       <= '0;
    for (int c = 0; c < CHANNELS; c++) begin
      restart_channel(c);
      body_cnt[c] = 0;
    end
    err_count = '0;
    frame_cap = MAX_FRAME_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_clean_message();
    test_ignored_bytes();
    test_dropped_messages();
    test_random_traffic(100);
    write_frame_cap(7'd64);
    test_random_traffic(200);
    write_frame_cap(7'd1);
    test_random_traffic(100);
    write_frame_cap(7'd63);
    test_random_traffic(200);
    write_frame_cap(7'd0);
    test_random_traffic(10);
    write_frame_cap(7'd5);
    test_random_traffic(130);
    write_frame_cap(7'd64);
    idle_en = 1'b0;
    test_random_traffic(130);
    test_error_frames();

    can_bytes.valid <= 1'b0;
    for (int guard = 0; guard < 20000 && pending_beats.size() != 0; guard++) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    if (pending_beats.size() != 0) begin
      report_mismatch($sformatf("%0d beats never arrived", pending_beats.size()));
    end
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #9600000;
    $display("simulation failed");
    $finish;
  end

endmodule
